FILE: rtl/bmp_dec_pkg.sv
// ----------------------------------------------------------------------------
// BMP decoder package
// Transfer payload types and header byte positions for the BMP pixel decoder.
// ----------------------------------------------------------------------------
package bmp_dec_pkg;

  localparam int MAX_DIM_DEF = 4096;

  // Header byte positions: first byte of each little-endian word, and last byte
  localparam logic [4:0] OFS_POS   = 5'd10;
  localparam logic [4:0] WIDTH_POS = 5'd18;
  localparam logic [4:0] HGT_POS   = 5'd22;
  localparam logic [4:0] BPP_POS   = 5'd28;
  localparam logic [4:0] CHECK_POS = 5'd31;
  localparam logic [31:0] HDR_LEN  = 32'd32;

  localparam int ROW_W   = 12;
  localparam int CHAN_W  = 3;

  typedef enum logic [1:0] {
    ST_PIXEL    = 2'd0,
    ST_BAD_CHAN = 2'd1,
    ST_BAD_SIZE = 2'd2
  } status_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_file;
  } in_data_t;

  typedef struct packed {
    status_t             status;
    logic [ROW_W-1:0]    row;
    logic [ROW_W-1:0]    column;
    logic [7:0]          red;
    logic [7:0]          green;
    logic [7:0]          blue;
    logic [7:0]          alpha;
    logic [CHAN_W-1:0]   channel_count;
    logic                last_pixel;
  } out_data_t;

endpackage

FILE: rtl/bmp_pixel_stream_decoder_core.sv
// ----------------------------------------------------------------------------
// BMP pixel stream decoder
// Parses an uncompressed BMP header byte by byte, then emits one result per
// completed pixel (file order, top-down row index) or one header error.
// ----------------------------------------------------------------------------
// Output: a result appears on the out_ bus in the cycle after the transfer of
// the byte that completes it. Throughput: one byte per cycle while the result
// register is free or being drained; the decode is a single pass of counter
// and byte-lane logic between the input transfer and the result register.
// Reset: rst_n (synchronous, active low) clears the parser and empties the
// result register; the parser also returns to its reset state after the byte
// flagged end_of_file.
module bmp_pixel_stream_decoder_core #(
  parameter int MAX_DIM = bmp_dec_pkg::MAX_DIM_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  bmp_dec_pkg::in_data_t  in_data,
  output logic                   out_valid,
  input  logic                   out_ready,
  output bmp_dec_pkg::out_data_t out_data
);
  import bmp_dec_pkg::*;

  // Counter widths: column/row indices reach MAX_DIM-1, sizes reach MAX_DIM
  localparam int CNT_W = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int DIM_W = $clog2(MAX_DIM + 1);

  // Replace one byte lane of a header word
  function automatic logic [31:0] put_byte(input logic [31:0] word,
                                           input logic [1:0] idx,
                                           input logic [7:0] b);
    logic [31:0] w;
    w = word;
    w[idx*8 +: 8] = b;
    return w;
  endfunction

  // Parser state
  logic [31:0]      pos_r, pos_nxt;
  logic [31:0]      ofs_r, ofs_nxt;
  logic [31:0]      width_r, width_nxt;
  logic [31:0]      height_r, height_nxt;
  logic [31:0]      bpp_r, bpp_nxt;
  logic [DIM_W-1:0] hm_r, hm_nxt;          // height magnitude, latched at the check
  logic [1:0]       pad_cfg_r, pad_cfg_nxt; // row padding, latched at the check
  logic [1:0]       bip_r, bip_nxt;
  logic [1:0]       pad_r, pad_nxt;
  logic [CNT_W-1:0] col_r, col_nxt;
  logic [CNT_W-1:0] frow_r, frow_nxt;
  logic [23:0]      held_r, held_nxt;
  logic             done_r, done_nxt;

  // Result register
  logic             out_valid_r;
  out_data_t        out_data_r;

  logic             in_fire;
  logic             res_valid;
  out_data_t        res;

  // Combinational helpers
  logic [7:0]       b;
  logic [4:0]       p5;
  logic [28:0]      chan_full;
  logic [31:0]      hm32;
  logic [31:0]      held_ext;
  logic [2:0]       ch;
  logic [DIM_W-1:0] col_inc;
  logic [DIM_W-1:0] frow_inc;
  logic [DIM_W-1:0] drow;
  logic             last;
  logic [CNT_W+ROW_W-1:0] row_ext;
  logic [CNT_W+ROW_W-1:0] col_ext;

  // Accept a byte whenever the result register is free or being drained
  assign in_ready  = !out_valid_r || out_ready;
  assign in_fire   = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign b  = in_data.data_byte;
  assign p5 = pos_r[4:0];
  assign ch = bpp_r[5:3];

  // Pixel-walk arithmetic
  assign col_inc  = DIM_W'(col_r) + DIM_W'(1);
  assign frow_inc = DIM_W'(frow_r) + DIM_W'(1);
  assign drow     = height_r[31] ? DIM_W'(frow_r) : (hm_r - DIM_W'(1) - DIM_W'(frow_r));
  assign last     = (col_inc == width_r[DIM_W-1:0]) && (frow_inc == hm_r);
  assign row_ext  = {{ROW_W{1'b0}}, drow[CNT_W-1:0]};
  assign col_ext  = {{ROW_W{1'b0}}, col_r};

  always_comb begin
    pos_nxt     = pos_r;
    ofs_nxt     = ofs_r;
    width_nxt   = width_r;
    height_nxt  = height_r;
    bpp_nxt     = bpp_r;
    hm_nxt      = hm_r;
    pad_cfg_nxt = pad_cfg_r;
    bip_nxt     = bip_r;
    pad_nxt     = pad_r;
    col_nxt     = col_r;
    frow_nxt    = frow_r;
    held_nxt    = held_r;
    done_nxt    = done_r;
    res_valid   = 1'b0;
    res         = '0;
    chan_full   = '0;
    hm32        = '0;
    held_ext    = '0;

    if (!done_r) begin
      if (pos_r < HDR_LEN) begin
        // Header: capture the four little-endian words
        if (p5 >= OFS_POS && p5 <= OFS_POS + 5'd3) begin
          ofs_nxt = put_byte(ofs_r, 2'(p5 - OFS_POS), b);
        end else if (p5 >= WIDTH_POS && p5 <= WIDTH_POS + 5'd3) begin
          width_nxt = put_byte(width_r, 2'(p5 - WIDTH_POS), b);
        end else if (p5 >= HGT_POS && p5 <= HGT_POS + 5'd3) begin
          height_nxt = put_byte(height_r, 2'(p5 - HGT_POS), b);
        end else if (p5 >= BPP_POS) begin
          bpp_nxt = put_byte(bpp_r, 2'(p5 - BPP_POS), b);
        end

        if (p5 == CHECK_POS) begin
          // Last header byte: validate channel count first, then sizes and offset
          chan_full = bpp_nxt[31:3];
          hm32      = height_r[31] ? (32'd0 - height_r) : height_r;
          if (chan_full != 29'd1 && chan_full != 29'd3 && chan_full != 29'd4) begin
            res_valid       = 1'b1;
            res.status      = ST_BAD_CHAN;
            res.last_pixel  = 1'b1;
            done_nxt        = 1'b1;
          end else if (width_r[31] || width_r > 32'(MAX_DIM) || hm32 > 32'(MAX_DIM) ||
                       ofs_r[31] || ofs_r < HDR_LEN) begin
            res_valid       = 1'b1;
            res.status      = ST_BAD_SIZE;
            res.last_pixel  = 1'b1;
            done_nxt        = 1'b1;
          end else if (width_r == 32'd0 || hm32 == 32'd0) begin
            // Empty image: nothing to emit
            done_nxt = 1'b1;
          end else begin
            hm_nxt      = hm32[DIM_W-1:0];
            pad_cfg_nxt = 2'(2'd0 - 2'(width_r[1:0] * bpp_nxt[4:3]));
            bip_nxt     = '0;
            pad_nxt     = '0;
            col_nxt     = '0;
            frow_nxt    = '0;
            held_nxt    = '0;
          end
        end
      end else if (pos_r >= ofs_r) begin
        if (pad_r != 2'd0) begin
          // Drop row padding
          pad_nxt = pad_r - 2'd1;
        end else if ({1'b0, bip_r} + 3'd1 < ch) begin
          // Hold earlier bytes of the pixel
          held_ext = put_byte({8'd0, held_r}, bip_r, b);
          held_nxt = held_ext[23:0];
          bip_nxt  = bip_r + 2'd1;
        end else begin
          res_valid         = 1'b1;
          res.status        = ST_PIXEL;
          res.row           = row_ext[ROW_W-1:0];
          res.column        = col_ext[ROW_W-1:0];
          res.channel_count = ch;
          res.last_pixel    = last;
          // Swap BGR(A) to RGB(A); a single channel goes out as gray on red
          unique case (ch)
            3'd1: begin
              res.red = b;
            end
            3'd3: begin
              res.red   = b;
              res.green = held_r[15:8];
              res.blue  = held_r[7:0];
            end
            default: begin
              res.red   = held_r[23:16];
              res.green = held_r[15:8];
              res.blue  = held_r[7:0];
              res.alpha = b;
            end
          endcase
          bip_nxt  = '0;
          held_nxt = '0;
          if (last) begin
            done_nxt = 1'b1;
          end else if (col_inc >= width_r[DIM_W-1:0]) begin
            // Advance to the next file row
            col_nxt  = '0;
            frow_nxt = frow_inc[CNT_W-1:0];
            pad_nxt  = pad_cfg_r;
          end else begin
            col_nxt = col_inc[CNT_W-1:0];
          end
        end
      end

      if (pos_r != '1) begin
        pos_nxt = pos_r + 32'd1;
      end
    end

    // End of file: return every state entry to its reset value
    if (in_data.end_of_file) begin
      pos_nxt     = '0;
      ofs_nxt     = '0;
      width_nxt   = '0;
      height_nxt  = '0;
      bpp_nxt     = '0;
      hm_nxt      = '0;
      pad_cfg_nxt = '0;
      bip_nxt     = '0;
      pad_nxt     = '0;
      col_nxt     = '0;
      frow_nxt    = '0;
      held_nxt    = '0;
      done_nxt    = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= '0;
      ofs_r       <= '0;
      width_r     <= '0;
      height_r    <= '0;
      bpp_r       <= '0;
      hm_r        <= '0;
      pad_cfg_r   <= '0;
      bip_r       <= '0;
      pad_r       <= '0;
      col_r       <= '0;
      frow_r      <= '0;
      held_r      <= '0;
      done_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_fire) begin
        pos_r       <= pos_nxt;
        ofs_r       <= ofs_nxt;
        width_r     <= width_nxt;
        height_r    <= height_nxt;
        bpp_r       <= bpp_nxt;
        hm_r        <= hm_nxt;
        pad_cfg_r   <= pad_cfg_nxt;
        bip_r       <= bip_nxt;
        pad_r       <= pad_nxt;
        col_r       <= col_nxt;
        frow_r      <= frow_nxt;
        held_r      <= held_nxt;
        done_r      <= done_nxt;
        out_valid_r <= res_valid;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Result payload: load only when a new result is produced
  always_ff @(posedge clk) begin
    if (in_fire && res_valid) begin
      out_data_r <= res;
    end
  end

endmodule
